// ----- rtl/core/kcspf_pkg.sv -----
// Shared widths, register codes, defaults and transfer types of the key-color speckle filter.
package kcspf_pkg;

  // Field widths.
  localparam int PIX_W      = 24;
  localparam int THR_W      = 5;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Default geometry.
  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_WINDOW_RADIUS = 2;
  localparam int MAX_HEIGHT        = 4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd3;

  // Register reset values.
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // One result pixel with its flags.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             eof;
  } result_t;

  // One item handed from the input stage to the window stage.
  typedef struct packed {
    logic             valid;
    logic             drain;
    logic [PIX_W-1:0] pixel;
    logic             emit_main;
    logic             emit_tail;
    logic             last_row;
    logic             inner;
  } item_t;

endpackage

// ----- rtl/core/kcspf_line_store.sv -----
// Line store memory: one word per column holding one pixel of each stored row.
module kcspf_line_store import kcspf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int LANES     = 2 * DEF_WINDOW_RADIUS,
  localparam int CW       = $clog2(MAX_WIDTH),
  localparam int SW       = $clog2(LANES)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [CW-1:0]               addr,
  input  logic                        wr_en,
  input  logic [SW-1:0]               wr_lane,
  input  logic [PIX_W-1:0]            wr_data,
  output logic [LANES-1:0][PIX_W-1:0] rd_data
);

  logic [LANES-1:0][PIX_W-1:0] mem [MAX_WIDTH];

  // Read returns the word as it was before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
    if (wr_en) begin
      mem[addr][wr_lane] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/kcspf_window.sv -----
// Window stage: column counts, centre-row pixels, filter decision and result bundle.
module kcspf_window import kcspf_pkg::*; #(
  parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS,
  localparam int LANES        = 2 * WINDOW_RADIUS,
  localparam int WIN          = 2 * WINDOW_RADIUS + 1,
  localparam int SW           = $clog2(LANES),
  localparam int CCW          = $clog2(LANES + 2),
  localparam int TW           = $clog2(WIN * WIN + 1),
  localparam int CMPW         = (TW > THR_W) ? TW : THR_W,
  localparam int PCW          = $clog2(WINDOW_RADIUS + 2)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [PIX_W-1:0]            key_color,
  input  logic [THR_W-1:0]            count_threshold,
  input  item_t                       item,
  input  logic [SW-1:0]               slot,
  input  logic [LANES-1:0][PIX_W-1:0] lanes,
  output logic [PCW-1:0]              push_count,
  output result_t                     push_data [WINDOW_RADIUS+1]
);

  logic [PIX_W-1:0] ccp [WINDOW_RADIUS+1];
  logic [PIX_W-1:0] ccp_next [WINDOW_RADIUS+1];
  logic [CCW-1:0]   cnt [WIN];
  logic [CCW-1:0]   cnt_next [WIN];
  logic [CCW-1:0]   col_cnt;
  logic [TW-1:0]    total;
  logic [SW:0]      cslot_sum;
  logic [SW-1:0]    cslot;
  logic [PIX_W-1:0] centre_pix;
  logic [PIX_W-1:0] main_pix;
  logic             thin;
  result_t          tail [WINDOW_RADIUS];

  // Non-key count of the new column: all stored rows plus the incoming pixel.
  always_comb begin
    col_cnt = CCW'(!item.drain && (item.pixel != key_color));
    for (int i = 0; i < LANES; i++) begin
      col_cnt = col_cnt + CCW'(lanes[i] != key_color);
    end
  end

  // The centre row sits WINDOW_RADIUS rows above the incoming one.
  always_comb begin
    cslot_sum = {1'b0, slot} + (SW + 1)'(WINDOW_RADIUS);
    if (cslot_sum >= (SW + 1)'(LANES)) begin
      cslot_sum = cslot_sum - (SW + 1)'(LANES);
    end
    cslot      = cslot_sum[SW-1:0];
    centre_pix = lanes[cslot];
  end

  // Shift the window by one column.
  always_comb begin
    ccp_next[0] = centre_pix;
    for (int j = 1; j <= WINDOW_RADIUS; j++) begin
      ccp_next[j] = ccp[j-1];
    end
    cnt_next[0] = col_cnt;
    for (int j = 1; j < WIN; j++) begin
      cnt_next[j] = cnt[j-1];
    end
    total = '0;
    for (int j = 0; j < WIN; j++) begin
      total = total + TW'(cnt_next[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= WINDOW_RADIUS; j++) begin
        ccp[j] <= '0;
      end
      for (int j = 0; j < WIN; j++) begin
        cnt[j] <= '0;
      end
    end else if (item.valid) begin
      ccp <= ccp_next;
      cnt <= cnt_next;
    end
  end

  // Filter decision for the centre pixel; a key pixel stays the key either way.
  always_comb begin
    thin     = CMPW'(total) < CMPW'(count_threshold);
    main_pix = (item.inner && thin) ? key_color : ccp_next[WINDOW_RADIUS];
  end

  // Build the result bundle: centre pixel, then the border pixels that end the row.
  always_comb begin
    for (int t = 0; t < WINDOW_RADIUS; t++) begin
      tail[t].pix  = ccp_next[WINDOW_RADIUS-1-t];
      tail[t].last = 1'b0;
      tail[t].eof  = item.last_row && (t == WINDOW_RADIUS - 1);
    end
    for (int i = 0; i <= WINDOW_RADIUS; i++) begin
      push_data[i] = '0;
    end
    if (item.emit_main) begin
      push_data[0].pix = main_pix;
      for (int t = 0; t < WINDOW_RADIUS; t++) begin
        push_data[t+1] = tail[t];
      end
    end else begin
      for (int t = 0; t < WINDOW_RADIUS; t++) begin
        push_data[t] = tail[t];
      end
    end
    if (item.emit_tail) begin
      if (item.emit_main) begin
        push_data[WINDOW_RADIUS].last = 1'b1;
      end else begin
        push_data[WINDOW_RADIUS-1].last = 1'b1;
      end
    end else if (item.emit_main) begin
      push_data[0].last = 1'b1;
    end
    push_count = '0;
    if (item.valid) begin
      push_count = PCW'(item.emit_main) + (item.emit_tail ? PCW'(WINDOW_RADIUS) : '0);
    end
  end

endmodule

// ----- rtl/core/kcspf_out_fifo.sv -----
// Result queue: takes a bundle of results per cycle and sends one per transfer.
module kcspf_out_fifo import kcspf_pkg::*; #(
  parameter int SLOTS = DEF_WINDOW_RADIUS + 1,
  parameter int AW    = 4,
  localparam int DEPTH = 1 << AW,
  localparam int PCW   = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [PCW-1:0]   push_count,
  input  result_t          push_data [SLOTS],
  output logic             room,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [PIX_W-1:0] out_pixel,
  output logic             last_of_run,
  output logic             end_of_frame
);

  result_t       mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;
  logic          pop;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (count != '0);
  assign out_pixel    = mem[rp].pix;
  assign last_of_run  = mem[rp].last;
  assign end_of_frame = mem[rp].eof;

  // Room for the bundle in the window stage and one more behind it.
  assign room = ((AW + 2)'(count) + (AW + 2)'(2 * SLOTS)) <= (AW + 2)'(DEPTH);

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (PCW'(i) < push_count) begin
        mem[wp + AW'(i)] <= push_data[i];
      end
    end
  end

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + AW'(push_count);
      rp    <= rp + AW'(pop);
      count <= count + (AW + 1)'(push_count) - (AW + 1)'(pop);
    end
  end

endmodule

// ----- rtl/core/key_color_sparse_pixel_filter_core.sv -----
// Top level of the key-color speckle filter: registers, raster position and stage wiring.
//
// Pixels enter in raster order, one per clock while pixel_stall is low. A pixel that
// differs from the key color and lies at least WINDOW_RADIUS from every edge becomes the
// key when fewer than count_threshold pixels of its centred window differ from the key;
// all others pass unchanged. Results run WINDOW_RADIUS rows and columns behind the input:
// the line store read and the item are registered, and the window stage writes its
// results into an output queue. The last column of a row releases WINDOW_RADIUS + 1
// results at once into the queue, which sends one per cycle while result_stall is low, so
// the sustained rate is one pixel per clock; pixel_stall rises only when a stalled output
// lets the queue fill. The line store is a single memory of MAX_WIDTH words, each holding
// one pixel of every stored row, read and written once per pixel at the current column. It
// needs no clearing pass after reset. Drain items push out the last rows of a frame. The
// user must write configuration through cfg_write, cfg_index and cfg_data only while the
// block is idle, which it does not check; writing frame width or height restarts the frame.
module key_color_sparse_pixel_filter_core import kcspf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  drain,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PIX_W-1:0]      out_pixel,
  output logic                  last_of_run,
  output logic                  end_of_frame,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LANES = 2 * WINDOW_RADIUS;
  localparam int WIN   = 2 * WINDOW_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(LANES);
  localparam int PCW   = $clog2(WINDOW_RADIUS + 2);
  localparam int QAW   = $clog2(4 * (WINDOW_RADIUS + 1));

  logic [PIX_W-1:0] key_color;
  logic [THR_W-1:0] count_threshold;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;

  logic [ROW_W-1:0] row_counter;
  logic [CW-1:0]    column_counter;
  logic [SW-1:0]    slot_counter;

  logic [ROW_W-1:0] fw_ext;
  logic [ROW_W-1:0] w_clamp;
  logic [ROW_W-1:0] h_clamp;
  logic [ROW_W-1:0] h_end;
  logic [CW-1:0]    w_last;

  logic             accept;
  logic             ignore;
  logic             restart;
  logic             act;
  logic [ROW_W-1:0] r_eff;
  logic [CW-1:0]    c_eff;
  logic [SW-1:0]    slot_eff;
  item_t            item_d;
  item_t            item_q;
  logic [SW-1:0]    slot_q;

  logic [LANES-1:0][PIX_W-1:0] rd_data;
  logic [PCW-1:0]              push_count;
  result_t                     push_data [WINDOW_RADIUS+1];
  logic                        room;

  // Frame size used clamped to what the window and line store allow.
  always_comb begin
    fw_ext = ROW_W'(frame_width);
    if (fw_ext < ROW_W'(WIN)) begin
      w_clamp = ROW_W'(WIN);
    end else if (fw_ext > ROW_W'(MAX_WIDTH)) begin
      w_clamp = ROW_W'(MAX_WIDTH);
    end else begin
      w_clamp = fw_ext;
    end
    if (frame_height < FH_W'(WIN)) begin
      h_clamp = ROW_W'(WIN);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_clamp = ROW_W'(MAX_HEIGHT);
    end else begin
      h_clamp = ROW_W'(frame_height);
    end
    h_end  = h_clamp + ROW_W'(WINDOW_RADIUS - 1);
    w_last = CW'(w_clamp - 1'b1);
  end

  // Input stage: position of this pixel, frame restart and drain handling.
  always_comb begin
    accept   = pixel_valid && !pixel_stall;
    ignore   = drain && (row_counter < h_clamp);
    restart  = !drain && (row_counter >= h_clamp);
    act      = accept && !ignore;
    r_eff    = restart ? '0 : row_counter;
    c_eff    = restart ? '0 : column_counter;
    slot_eff = restart ? '0 : slot_counter;

    item_d.valid     = act;
    item_d.drain     = drain;
    item_d.pixel     = pixel;
    item_d.emit_main = (r_eff >= ROW_W'(WINDOW_RADIUS)) && (c_eff >= CW'(WINDOW_RADIUS));
    item_d.emit_tail = (r_eff >= ROW_W'(WINDOW_RADIUS)) && (c_eff == w_last);
    item_d.last_row  = (r_eff == h_end);
    item_d.inner     = (r_eff >= ROW_W'(LANES)) && (r_eff < h_clamp) &&
                       (c_eff >= CW'(LANES));
  end

  assign pixel_stall = !room;

  // Configuration registers and raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_color       <= '0;
      count_threshold <= '0;
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      row_counter     <= '0;
      column_counter  <= '0;
      slot_counter    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_COLOR: begin
          key_color <= cfg_data[PIX_W-1:0];
        end
        REG_COUNT_THRESHOLD: begin
          count_threshold <= cfg_data[THR_W-1:0];
        end
        REG_FRAME_WIDTH: begin
          frame_width    <= cfg_data[FW_W-1:0];
          row_counter    <= '0;
          column_counter <= '0;
          slot_counter   <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height   <= cfg_data[FH_W-1:0];
          row_counter    <= '0;
          column_counter <= '0;
          slot_counter   <= '0;
        end
        default: begin
        end
      endcase
    end else if (act) begin
      if (c_eff == w_last) begin
        column_counter <= '0;
        if (r_eff == h_end) begin
          row_counter  <= '0;
          slot_counter <= '0;
        end else begin
          row_counter  <= r_eff + 1'b1;
          slot_counter <= (slot_eff == SW'(LANES - 1)) ? '0 : slot_eff + 1'b1;
        end
      end else begin
        column_counter <= c_eff + 1'b1;
        row_counter    <= r_eff;
        slot_counter   <= slot_eff;
      end
    end
  end

  // Item register in step with the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk) begin
    slot_q <= slot_eff;
  end

  kcspf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .LANES     (LANES)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (act),
    .addr    (c_eff),
    .wr_en   (act && !drain),
    .wr_lane (slot_eff),
    .wr_data (pixel),
    .rd_data (rd_data)
  );

  kcspf_window #(
    .WINDOW_RADIUS (WINDOW_RADIUS)
  ) u_window (
    .clk             (clk),
    .rst             (rst),
    .key_color       (key_color),
    .count_threshold (count_threshold),
    .item            (item_q),
    .slot            (slot_q),
    .lanes           (rd_data),
    .push_count      (push_count),
    .push_data       (push_data)
  );

  kcspf_out_fifo #(
    .SLOTS (WINDOW_RADIUS + 1),
    .AW    (QAW)
  ) u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push_data    (push_data),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_pixel    (out_pixel),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

endmodule
